### src/assert_macros.svh
// assertion macros used by the icon cache core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define RCIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define RCIC_NEVER(label, cond, msg) \
    `RCIC_ASSERT(label, !(cond), msg)

`endif

### src/rcic_pkg.sv
// types, constants and codes for the reference counted icon cache
`default_nettype none

package rcic_pkg;

    localparam int CACHE_ENTRIES_DEF = 8;
    localparam int ICON_IDS          = 16;

    localparam int ID_W     = 4;
    localparam int DIM_W    = 10;
    localparam int DEPTH_W  = 6;
    localparam int HANDLE_W = 16;
    localparam int REFS_W   = 16;
    localparam int STATUS_W = 4;
    localparam int MASK_W   = 15;

    localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(63);

    localparam logic CMD_LOCK   = 1'b0;
    localparam logic CMD_UNLOCK = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT       = 4'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_UNCACHED  = 4'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ID    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_UNREG     = 4'd4;
    localparam logic [STATUS_W-1:0] ST_LOAD_FAIL = 4'd5;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_DESTROY   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_NULL      = 4'd8;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [REFS_W-1:0]   refs;
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [DEPTH_W-1:0]  depth;
    } entry_t;

    typedef struct packed {
        logic                cmd;
        logic [ID_W-1:0]     icon_id;
        logic [DIM_W-1:0]    req_width;
        logic [DIM_W-1:0]    req_height;
        logic [DEPTH_W-1:0]  req_depth;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic              key_hit;
        logic              handle_hit;
        logic              refs_zero;
        logic [REFS_W-1:0] refs_inc;
        logic [REFS_W-1:0] refs_dec;
    } cmp_t;

endpackage

`default_nettype wire

### src/refcounted_icon_cache_core.sv
// top level of the reference counted icon cache: sequencer, config and result registers
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    cmd icon_id req_width req_height req_depth handle_in
//  out       output     out_valid / out_stall  status handle_out evict_valid evicted_handle
//  cfg       input      cfg_valid / cfg_ready  registered_mask
//
//  one entry is read and compared per cycle through a single memory read port
//  unlock or lock hit at entry k: entries 0 to k scanned, then result; bad id or null: no scan
//  lock miss with free entry f: full forward scan, backward scan to f, shift below f, insert at 0
//  reset clears control state and entry valid bits at once, no clearing pass
//  one item at a time; a new item is taken while the previous result waits on out_stall
`default_nettype none

`include "assert_macros.svh"

module refcounted_icon_cache_core
    import rcic_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                cmd,
    input  wire logic [ID_W-1:0]     icon_id,
    input  wire logic [DIM_W-1:0]    req_width,
    input  wire logic [DIM_W-1:0]    req_height,
    input  wire logic [DEPTH_W-1:0]  req_depth,
    input  wire logic [HANDLE_W-1:0] handle_in,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [HANDLE_W-1:0]      handle_out,
    output logic                     evict_valid,
    output logic [HANDLE_W-1:0]      evicted_handle,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [MASK_W-1:0]   registered_mask
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FWD   = 3'd1;
    localparam logic [2:0] S_BWD   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    req_t                req_reg, req_next;
    logic [MASK_W-1:0]   mask_reg;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_hout_reg, res_hout_next;
    logic                res_ev_reg, res_ev_next;
    logic [HANDLE_W-1:0] res_evh_reg, res_evh_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_hout_reg;
    logic                out_ev_reg;
    logic [HANDLE_W-1:0] out_evh_reg;

    entry_t              rd_data;
    entry_t              wr_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    cmp_t                cmp;

    logic                in_xfer;
    logic                out_load;
    logic                bad_id;
    logic                reg_ok;
    logic [ID_W-1:0]     id_bit;
    logic [MASK_W:0]     mask_ext;

    rcic_store #(
        .ENTRIES (CACHE_ENTRIES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_next),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rcic_cmp u_cmp (
        .req (req_reg),
        .ent (rd_data),
        .res (cmp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_RES) && (!out_valid_reg || !out_stall);

    assign bad_id   = (icon_id == '0) || (32'(icon_id) >= ICON_IDS);
    // ids past the mask width count as unregistered
    assign id_bit   = req_reg.icon_id - ID_W'(1);
    assign mask_ext = {1'b0, mask_reg};
    assign reg_ok   = (32'(id_bit) < MASK_W) && mask_ext[id_bit];

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        req_next        = req_reg;
        res_status_next = res_status_reg;
        res_hout_next   = res_hout_reg;
        res_ev_next     = res_ev_reg;
        res_evh_next    = res_evh_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (in_xfer)
                begin
                    req_next.cmd        = cmd;
                    req_next.icon_id    = icon_id;
                    req_next.req_width  = req_width;
                    req_next.req_height = req_height;
                    req_next.req_depth  = req_depth;
                    req_next.handle_in  = handle_in;
                    res_hout_next       = '0;
                    res_ev_next         = 1'b0;
                    res_evh_next        = '0;
                    if (cmd == CMD_UNLOCK && handle_in == '0)
                    begin
                        res_status_next = ST_NULL;
                        state_next      = S_RES;
                    end
                    else if (cmd == CMD_LOCK && bad_id)
                    begin
                        res_status_next = ST_BAD_ID;
                        state_next      = S_RES;
                    end
                    else
                    begin
                        state_next = S_FWD;
                    end
                end
            end
            S_FWD:
            begin
                if (req_reg.cmd == CMD_UNLOCK)
                begin
                    if (cmp.handle_hit)
                    begin
                        wr_en           = 1'b1;
                        wr_data.refs    = cmp.refs_dec;
                        res_status_next = ST_RELEASED;
                        state_next      = S_RES;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        res_status_next = ST_DESTROY;
                        res_hout_next   = req_reg.handle_in;
                        state_next      = S_RES;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    if (cmp.key_hit)
                    begin
                        wr_en           = 1'b1;
                        wr_data.refs    = cmp.refs_inc;
                        res_status_next = ST_HIT;
                        res_hout_next   = rd_data.handle;
                        state_next      = S_RES;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        if (!reg_ok)
                        begin
                            res_status_next = ST_UNREG;
                            state_next      = S_RES;
                        end
                        else if (req_reg.handle_in == '0)
                        begin
                            res_status_next = ST_LOAD_FAIL;
                            state_next      = S_RES;
                        end
                        else
                        begin
                            idx_next   = LAST_IDX;
                            state_next = S_BWD;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_BWD:
            begin
                if (cmp.refs_zero)
                begin
                    res_ev_next  = (rd_data.handle != '0);
                    res_evh_next = rd_data.handle;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_reg == '0)
                begin
                    res_status_next = ST_UNCACHED;
                    res_hout_next   = req_reg.handle_in;
                    state_next      = S_RES;
                end
                else
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            S_SHIFT:
            begin
                // move entry idx up by one
                wr_en   = 1'b1;
                wr_addr = idx_reg + IDX_W'(1);
                if (idx_reg == '0)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            S_INS:
            begin
                wr_en           = 1'b1;
                wr_addr         = '0;
                wr_data.id      = req_reg.icon_id;
                wr_data.refs    = REFS_W'(1);
                wr_data.handle  = req_reg.handle_in;
                wr_data.width   = req_reg.req_width;
                wr_data.height  = req_reg.req_height;
                wr_data.depth   = req_reg.req_depth;
                res_status_next = ST_INSERTED;
                res_hout_next   = req_reg.handle_in;
                state_next      = S_RES;
            end
            S_RES:
            begin
                idx_next = '0;
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            mask_reg      <= MASK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= registered_mask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_hout_reg   <= res_hout_next;
        res_ev_reg     <= res_ev_next;
        res_evh_reg    <= res_evh_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_hout_reg   <= res_hout_reg;
            out_ev_reg     <= res_ev_reg;
            out_evh_reg    <= res_ev_reg ? res_evh_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign handle_out     = out_hout_reg;
    assign evict_valid    = out_ev_reg;
    assign evicted_handle = out_evh_reg;

    `RCIC_NEVER(a_no_write_idle, wr_en && state_reg == S_IDLE, "entry write while idle")
    `RCIC_ASSERT(a_result_from_res, $rose(out_valid_reg) |-> $past(state_reg == S_RES), "result not from result state")
    `RCIC_ASSERT(a_evict_on_insert, out_valid_reg && out_ev_reg |-> out_status_reg == ST_INSERTED && out_evh_reg != '0, "eviction without insert")

endmodule

`default_nettype wire

### src/rcic_store.sv
// entry memory with per-entry valid bits and registered read
`default_nettype none

module rcic_store
    import rcic_pkg::*;
#(
    parameter int ENTRIES = CACHE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(ENTRIES)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  entry_t                wr_data
);

    entry_t             mem_reg [ENTRIES];
    entry_t             rd_mem_reg;
    logic [ENTRIES-1:0] vld_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem_reg[rd_addr];
    end

    // entries never written read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire

### src/rcic_cmp.sv
// shared compare and count unit applied to one entry per cycle
`default_nettype none

module rcic_cmp
    import rcic_pkg::*;
(
    input  req_t   req,
    input  entry_t ent,
    output cmp_t   res
);

    always_comb
    begin
        res.key_hit    = (ent.id == req.icon_id) && (ent.width == req.req_width)
                         && (ent.height == req.req_height) && (ent.depth == req.req_depth);
        res.handle_hit = (ent.handle == req.handle_in);
        res.refs_zero  = (ent.refs == '0);
        // saturate at the top, floor at zero
        res.refs_inc   = (&ent.refs) ? ent.refs : ent.refs + REFS_W'(1);
        res.refs_dec   = res.refs_zero ? ent.refs : ent.refs - REFS_W'(1);
    end

endmodule

`default_nettype wire

### tb/refcounted_icon_cache_checker.sv
// checker for the icon cache: predicts the answer to each request transfer and compares results
module refcounted_icon_cache_checker
    import rcic_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic                cmd,
    input  wire logic [ID_W-1:0]     icon_id,
    input  wire logic [DIM_W-1:0]    req_width,
    input  wire logic [DIM_W-1:0]    req_height,
    input  wire logic [DEPTH_W-1:0]  req_depth,
    input  wire logic [HANDLE_W-1:0] handle_in,

    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [STATUS_W-1:0] status,
    input  wire logic [HANDLE_W-1:0] handle_out,
    input  wire logic                evict_valid,
    input  wire logic [HANDLE_W-1:0] evicted_handle,

    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [MASK_W-1:0]   registered_mask,

    output int                       fail_count,
    output int                       pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic                evict;
        logic [HANDLE_W-1:0] evicted;
    } answer_t;

    entry_t            slots [CACHE_ENTRIES];
    logic [MASK_W-1:0] mask_q;
    answer_t           answers [$];
    int                fails;

    function automatic answer_t serve_request(input req_t r);
        answer_t a;
        int      i;
        int      found;
        int      bit_no;
        a = '0;
        found = -1;
        if (r.cmd == CMD_UNLOCK) begin
            if (r.handle_in == '0) begin
                a.status = ST_NULL;
            end else begin
                for (i = 0; i < CACHE_ENTRIES && found < 0; i++)
                    if (slots[i].handle == r.handle_in)
                        found = i;
                if (found < 0) begin
                    a.status = ST_DESTROY;
                    a.handle = r.handle_in;
                end else begin
                    if (slots[found].refs != '0)
                        slots[found].refs = slots[found].refs - REFS_W'(1);
                    a.status = ST_RELEASED;
                end
            end
        end else if (r.icon_id == '0 || int'(r.icon_id) >= ICON_IDS) begin
            a.status = ST_BAD_ID;
        end else begin
            for (i = 0; i < CACHE_ENTRIES && found < 0; i++)
                if (slots[i].id == r.icon_id && slots[i].width == r.req_width &&
                    slots[i].height == r.req_height && slots[i].depth == r.req_depth)
                    found = i;
            bit_no = int'(r.icon_id) - 1;
            if (found >= 0) begin
                if (slots[found].refs != '1)
                    slots[found].refs = slots[found].refs + REFS_W'(1);
                a.status = ST_HIT;
                a.handle = slots[found].handle;
            end else if (bit_no >= MASK_W || !mask_q[bit_no]) begin
                a.status = ST_UNREG;
            end else if (r.handle_in == '0) begin
                a.status = ST_LOAD_FAIL;
            end else begin
                for (i = CACHE_ENTRIES - 1; i >= 0 && found < 0; i--)
                    if (slots[i].refs == '0)
                        found = i;
                a.handle = r.handle_in;
                if (found < 0) begin
                    a.status = ST_UNCACHED;
                end else begin
                    if (slots[found].handle != '0) begin
                        a.evict   = 1'b1;
                        a.evicted = slots[found].handle;
                    end
                    for (i = found; i > 0; i--)
                        slots[i] = slots[i-1];
                    slots[0].id     = r.icon_id;
                    slots[0].refs   = REFS_W'(1);
                    slots[0].handle = r.handle_in;
                    slots[0].width  = r.req_width;
                    slots[0].height = r.req_height;
                    slots[0].depth  = r.req_depth;
                    a.status = ST_INSERTED;
                end
            end
        end
        return a;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        answer_t want;
        int      i;
        if (!rst_n) begin
            for (i = 0; i < CACHE_ENTRIES; i++)
                slots[i] = '0;
            mask_q = MASK_RESET;
            answers.delete();
            fails = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                mask_q = registered_mask;
            if (out_valid && !out_stall) begin
                if (answers.size() == 0) begin
                    $display("%0t: result expected none actual status %0d handle %0d",
                             $time, status, handle_out);
                    fails++;
                end else begin
                    want = answers.pop_front();
                    check_field("status", int'(want.status), int'(status));
                    check_field("handle_out", int'(want.handle), int'(handle_out));
                    check_field("evict_valid", int'(want.evict), int'(evict_valid));
                    check_field("evicted_handle", int'(want.evicted), int'(evicted_handle));
                end
            end
            if (in_valid && !in_stall)
                answers.push_back(serve_request({cmd, icon_id, req_width, req_height,
                                                 req_depth, handle_in}));
        end
        pending    <= answers.size();
        fail_count <= fails;
    end

endmodule

### tb/refcounted_icon_cache_core_test.sv
// stimulus and verdict for the reference counted icon cache core
module refcounted_icon_cache_core_test;
    import rcic_pkg::*;

    localparam int ENTRIES     = CACHE_ENTRIES_DEF;
    localparam int BURST_HITS  = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int POOL_DEPTH  = 12;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [DEPTH_W-1:0] depth;
    } icon_key_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                cmd;
    logic [ID_W-1:0]     icon_id;
    logic [DIM_W-1:0]    req_width;
    logic [DIM_W-1:0]    req_height;
    logic [DEPTH_W-1:0]  req_depth;
    logic [HANDLE_W-1:0] handle_in;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic                evict_valid;
    logic [HANDLE_W-1:0] evicted_handle;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [MASK_W-1:0]   registered_mask;

    int                  fail_count;
    int                  pending;
    bit                  idle_off;
    icon_key_t           key_pool [$];
    logic [HANDLE_W-1:0] handle_pool [$];

    refcounted_icon_cache_core #(.CACHE_ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .icon_id(icon_id),
        .req_width(req_width), .req_height(req_height), .req_depth(req_depth),
        .handle_in(handle_in),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .handle_out(handle_out), .evict_valid(evict_valid), .evicted_handle(evicted_handle),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .registered_mask(registered_mask)
    );

    refcounted_icon_cache_checker #(.CACHE_ENTRIES(ENTRIES)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .icon_id(icon_id),
        .req_width(req_width), .req_height(req_height), .req_depth(req_depth),
        .handle_in(handle_in),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .handle_out(handle_out), .evict_valid(evict_valid), .evicted_handle(evicted_handle),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .registered_mask(registered_mask),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic icon_key_t make_key(input int id, input int w, input int h, input int d);
        icon_key_t k;
        k.id     = ID_W'(id);
        k.width  = DIM_W'(w);
        k.height = DIM_W'(h);
        k.depth  = DEPTH_W'(d);
        return k;
    endfunction

    function automatic req_t lock_req(input icon_key_t k, input logic [HANDLE_W-1:0] h);
        req_t r;
        r.cmd        = CMD_LOCK;
        r.icon_id    = k.id;
        r.req_width  = k.width;
        r.req_height = k.height;
        r.req_depth  = k.depth;
        r.handle_in  = h;
        return r;
    endfunction

    function automatic req_t unlock_req(input logic [HANDLE_W-1:0] h);
        req_t r;
        r.cmd        = CMD_UNLOCK;
        r.icon_id    = ID_W'($urandom_range(0, 15));
        r.req_width  = DIM_W'($urandom_range(0, 1023));
        r.req_height = DIM_W'($urandom_range(0, 1023));
        r.req_depth  = DEPTH_W'($urandom_range(0, 63));
        r.handle_in  = h;
        return r;
    endfunction

    function automatic icon_key_t pick_key();
        icon_key_t k;
        int        roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            k = make_key($urandom_range(0, 15), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 63));
        end else if (roll < 70 && key_pool.size() != 0) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else begin
            k.id     = ID_W'($urandom_range(1, ICON_IDS - 1));
            k.width  = DIM_W'(16 * $urandom_range(1, 4));
            k.height = ($urandom_range(0, 1) != 0) ? k.width : 10'd24;
            k.depth  = DEPTH_W'(8 * $urandom_range(0, 4));
        end
        return k;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_lock_handle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return '0;
        if (roll < 16 && handle_pool.size() != 0)
            return handle_pool[$urandom_range(0, handle_pool.size() - 1)];
        return HANDLE_W'($urandom_range(1, 65535));
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_unlock_handle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return '0;
        if (roll < 16 || handle_pool.size() == 0)
            return HANDLE_W'($urandom_range(1, 65535));
        return handle_pool[$urandom_range(0, handle_pool.size() - 1)];
    endfunction

    task automatic remember(input icon_key_t k, input logic [HANDLE_W-1:0] h);
        key_pool.push_back(k);
        if (key_pool.size() > POOL_DEPTH)
            key_pool.delete(0);
        if (h != '0) begin
            handle_pool.push_back(h);
            if (handle_pool.size() > POOL_DEPTH)
                handle_pool.delete(0);
        end
    endtask

    // returns at the edge of the transfer with in_valid still high
    task automatic send_request(input req_t r);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {cmd, icon_id, req_width, req_height, req_depth, handle_in} <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] value);
        drain_requests();
        cfg_valid       <= 1'b1;
        registered_mask <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("refcounted_icon_cache_core_test failed");
        $finish;
    end

    initial begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            n = idle_off ? 0 : $urandom_range(0, 15);
            if (n != 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        icon_key_t           big_key;
        icon_key_t           dup_key;
        icon_key_t           k;
        logic [HANDLE_W-1:0] h;
        logic [MASK_W-1:0]   phase_mask;
        int                  lock_pct;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        cmd             <= CMD_LOCK;
        icon_id         <= '0;
        req_width       <= '0;
        req_height      <= '0;
        req_depth       <= '0;
        handle_in       <= '0;
        cfg_valid       <= 1'b0;
        registered_mask <= '0;
        idle_off         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(lock_req(make_key(0, 32, 32, 8), 16'd100));
        send_request(lock_req(make_key(7, 32, 32, 8), 16'd100));
        send_request(lock_req(make_key(1, 0, 0, 0), '0));
        big_key = make_key(1, 1023, 1023, 63);
        send_request(lock_req(big_key, 16'hFFFF));
        send_request(lock_req(big_key, 16'h5555));
        send_request(unlock_req('0));
        send_request(unlock_req(16'h1234));
        // count goes to zero and then stays there
        repeat (3) send_request(unlock_req(16'hFFFF));
        // fill every entry, the last insert evicts the released one
        for (int i = 1; i <= ENTRIES; i++)
            send_request(lock_req(make_key((i - 1) % 6 + 1, 16 * i, 16, 8), HANDLE_W'(i)));
        send_request(lock_req(make_key(2, 100, 100, 16), 16'd9));
        send_request(unlock_req(16'd1));
        // second entry with an already cached handle, unlock hits the front one
        dup_key = make_key(3, 200, 200, 24);
        send_request(lock_req(dup_key, 16'd2));
        send_request(unlock_req(16'd2));
        send_request(lock_req(make_key(15, 8, 8, 1), 16'd77));
        write_mask({MASK_W{1'b1}});
        send_request(lock_req(make_key(15, 8, 8, 1), 16'd77));

        // back to back hits on one entry
        idle_off = 1'b1;
        repeat (BURST_HITS) send_request(lock_req(make_key(15, 8, 8, 1), 16'd78));
        send_request(unlock_req(16'd77));
        idle_off = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                phase_mask = {MASK_W{1'b1}};
            else if (p == 1)
                phase_mask = '0;
            else if (p == PHASES - 1)
                phase_mask = MASK_RESET;
            else
                phase_mask = MASK_W'($urandom_range(0, 32767));
            write_mask(phase_mask);
            idle_off = ($urandom_range(0, 3) == 0);
            lock_pct = 30 + 20 * $urandom_range(0, 3);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < lock_pct) begin
                    k = pick_key();
                    h = pick_lock_handle();
                    send_request(lock_req(k, h));
                    remember(k, h);
                end else begin
                    send_request(unlock_req(pick_unlock_handle()));
                end
            end
        end
        idle_off = 1'b0;

        drain_requests();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("refcounted_icon_cache_core_test passed");
        else
            $display("refcounted_icon_cache_core_test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/rcic_pkg.sv
src/rcic_store.sv
src/rcic_cmp.sv
src/refcounted_icon_cache_core.sv
tb/refcounted_icon_cache_checker.sv
tb/refcounted_icon_cache_core_test.sv
